// ----- rtl/core/itp_pkg.sv -----
// shared types and constants for the integer text parser
package itp_pkg;

	localparam int unsigned RADIX_W    = 6;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned DIGIT_W    = 6;
	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned CONSUMED_W = 16;

	localparam longint unsigned COUNT_MAX_DEF  = 64'd65535;
	localparam int unsigned     VALUE_BITS_DEF = 64;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

	localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

	typedef enum logic [2:0] {
		PH_DONE,
		PH_SPACE,
		PH_PREFIX,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic               start;
		logic [RADIX_W-1:0] radix;
		logic [DIGIT_W-1:0] digit;
		logic               is_space;
		logic               is_minus;
		logic               is_plus;
		logic               is_x;
	} item_t;

endpackage

// ----- rtl/core/integer_text_parser.sv -----
// integer text parser top level
// the ending item passes through the item queue and then the result register before its result leaves
// throughput: one item per cycle while in_stall is low; the back end accumulates one digit per cycle (64 x 6 multiply)
// the four-entry item queue absorbs result stalls until it fills
// reset: arst_n clears the queue, the parse phase and the result valid
// an item with start_req set opens a new string at any time
module integer_text_parser import itp_pkg::*; #(
	parameter longint unsigned COUNT_MAX  = COUNT_MAX_DEF,
	parameter int unsigned     VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  start_req,
	input  logic [RADIX_W-1:0]    radix,
	input  logic [CHAR_W-1:0]     char_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_W-1:0]    value,
	output logic [CONSUMED_W-1:0] consumed
);

	logic  head_valid;
	item_t head;
	logic  pop;

	itp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_req  (start_req),
		.radix      (radix),
		.char_in    (char_in),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	itp_back #(
		.COUNT_MAX  (COUNT_MAX),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.consumed   (consumed)
	);

endmodule

// ----- rtl/core/itp_front.sv -----
// front end: character classification and item queue
module itp_front import itp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              start_req,
	input  logic [RADIX_W-1:0] radix,
	input  logic [CHAR_W-1:0] char_in,
	output logic              head_valid,
	output item_t             head,
	input  logic              pop
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_X    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
	localparam logic [CHAR_W-1:0] UP_OFFSET  = 8'd55;
	localparam logic [CHAR_W-1:0] LO_OFFSET  = 8'd87;

	item_t            queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	item_t            cls;

	always_comb begin
		cls          = '0;
		cls.start    = start_req;
		cls.radix    = radix;
		cls.is_space = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
		cls.is_minus = (char_in == CH_MINUS);
		cls.is_plus  = (char_in == CH_PLUS);
		cls.is_x     = (char_in == CH_LO_X) || (char_in == CH_UP_X);
		if (char_in >= CH_ZERO && char_in <= CH_NINE) begin
			cls.digit = DIGIT_W'(char_in - CH_ZERO);
		end else if (char_in >= CH_LO_A && char_in <= CH_LO_Z) begin
			cls.digit = DIGIT_W'(char_in - LO_OFFSET);
		end else if (char_in >= CH_UP_A && char_in <= CH_UP_Z) begin
			cls.digit = DIGIT_W'(char_in - UP_OFFSET);
		end else begin
			cls.digit = DIGIT_NONE;
		end
	end

	assign in_stall   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	// pointers wrap at the power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

// ----- rtl/core/itp_back.sv -----
// back end: parse state machine, accumulator and result register
module itp_back import itp_pkg::*; #(
	parameter longint unsigned COUNT_MAX  = COUNT_MAX_DEF,
	parameter int unsigned     VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  item_t                 head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_W-1:0]    value,
	output logic [CONSUMED_W-1:0] consumed
);

	localparam int unsigned CNT_W = $clog2(COUNT_MAX + 64'd1);

	phase_t                  phase_q;
	phase_t                  phase_n;
	logic [VALUE_BITS-1:0]   acc_q;
	logic [VALUE_BITS-1:0]   acc_n;
	logic                    neg_q;
	logic                    neg_n;
	logic [RADIX_W-1:0]      wr_q;
	logic [RADIX_W-1:0]      wr_n;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        cnt_n;
	logic [VALUE_BITS-1:0]   prod;
	logic [VALUE_BITS-1:0]   result;
	logic                    count;
	logic                    do_digit;
	logic                    emit;
	logic                    out_valid_q;
	logic [VALUE_W-1:0]      value_q;
	logic [CONSUMED_W-1:0]   consumed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
		end else if (pop) begin
			phase_q <= phase_n;
		end
	end

	always_comb begin
		phase_n  = (head_valid && head.start) ? PH_SPACE : phase_q;
		acc_n    = head.start ? '0 : acc_q;
		neg_n    = head.start ? 1'b0 : neg_q;
		wr_n     = head.start ? head.radix : wr_q;
		cnt_n    = head.start ? '0 : cnt_q;
		count    = 1'b0;
		do_digit = 1'b0;
		emit     = 1'b0;
		prod     = '0;
		unique case (phase_n)
			PH_DONE: begin
			end
			PH_SPACE, PH_PREFIX: begin
				if (phase_n == PH_SPACE && head.is_space) begin
					count = 1'b1;
				end else if (phase_n == PH_SPACE && head.is_minus) begin
					neg_n   = 1'b1;
					count   = 1'b1;
					phase_n = PH_PREFIX;
				end else if (phase_n == PH_SPACE && head.is_plus) begin
					count   = 1'b1;
					phase_n = PH_PREFIX;
				end else if (head.digit == '0 && (wr_n == RADIX_AUTO || wr_n == RADIX_HEX)) begin
					count   = 1'b1;
					phase_n = PH_ZERO;
				end else begin
					if (wr_n == RADIX_AUTO) begin
						wr_n = RADIX_DEC;
					end
					do_digit = 1'b1;
				end
			end
			PH_ZERO: begin
				if (head.is_x) begin
					wr_n    = RADIX_HEX;
					count   = 1'b1;
					phase_n = PH_DIGITS;
				end else begin
					if (wr_n == RADIX_AUTO) begin
						wr_n = RADIX_OCT;
					end
					do_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				do_digit = 1'b1;
			end
			default: begin
			end
		endcase
		if (do_digit) begin
			if (head.digit < wr_n) begin
				prod    = acc_n * VALUE_BITS'(wr_n);
				acc_n   = prod + VALUE_BITS'(head.digit);
				count   = 1'b1;
				phase_n = PH_DIGITS;
			end else begin
				emit    = 1'b1;
				phase_n = PH_DONE;
			end
		end
		if (count && cnt_n < CNT_W'(COUNT_MAX)) begin
			cnt_n = cnt_n + 1'b1;
		end
	end

	assign result = neg_n ? (VALUE_BITS'(0) - acc_n) : acc_n;
	assign pop    = head_valid && (!emit || !out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= acc_n;
			neg_q <= neg_n;
			wr_q  <= wr_n;
			cnt_q <= cnt_n;
		end
		if (pop && emit) begin
			value_q    <= VALUE_W'(signed'(result));
			consumed_q <= CONSUMED_W'(cnt_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign consumed  = consumed_q;

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop && emit |=> phase_q == PH_DONE && out_valid_q)
		else $error("result issued without ending the parse");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop && emit))
		else $error("result appeared without an ending item");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE && !(pop && head.start) |=> phase_q == PH_DONE)
		else $error("parse left done without a start");

endmodule
